[hw/rtl/median_then_weighted_average_filter_macros.svh]
// Assertion macros for the humidity filter.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MEDIAN_THEN_WEIGHTED_AVERAGE_FILTER_MACROS_SVH
`define MEDIAN_THEN_WEIGHTED_AVERAGE_FILTER_MACROS_SVH

// Same-cycle implication.
`define MTWA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTWA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mtwa_pkg.sv]
// Shared widths, register indexes, reset values and types of the humidity filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtwa_pkg;

  localparam int VAL_W     = 10;   // reading, median and output width
  localparam int WGT_W     = 8;    // weight width
  localparam int WCOUNT    = 4;    // number of weight registers
  localparam int CFG_IDX_W = 2;
  localparam int WSUM_W    = 10;   // sum of four 8-bit weights
  localparam int NUM_W     = 21;   // weighted sum plus half the weight sum
  localparam int QUO_W     = 11;   // quotient bits, result stays below 2^11

  localparam logic [CFG_IDX_W-1:0] REG_W_NEWEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_OLDEST = 2'd3;

  localparam logic [WGT_W-1:0] WGT_RESET [WCOUNT] = '{8'd50, 8'd25, 8'd15, 8'd10};
  localparam logic [VAL_W-1:0] LAST_RESET = 10'd190;

  typedef struct packed {
    logic shift;   // take the lower neighbor's value
    logic rotate;  // take the upper neighbor's value
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/mtwa_if.sv]
// Valid/ready channel interfaces for the humidity filter input and result.
// Depends on mtwa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mtwa_in_if;
  logic                       valid;
  logic                       ready;
  logic [mtwa_pkg::VAL_W-1:0] reading;
  logic                       sensor_fault;

  modport source (output valid, output reading, output sensor_fault, input ready);
  modport sink   (input valid, input reading, input sensor_fault, output ready);
endinterface

interface mtwa_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtwa_pkg::VAL_W-1:0] humidity;
  logic                       fault;

  modport source (output valid, output humidity, output fault, input ready);
  modport sink   (input valid, input humidity, input fault, output ready);
endinterface

`default_nettype wire

[hw/rtl/mtwa_cell.sv]
// One window cell: a value register that loads from either neighbor.
// Depends on mtwa_pkg for the value width and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module mtwa_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  mtwa_pkg::cell_ctl_t       ctl_i,
  input  wire  [mtwa_pkg::VAL_W-1:0]      prev_i,
  input  wire  [mtwa_pkg::VAL_W-1:0]      next_i,
  output logic [mtwa_pkg::VAL_W-1:0]      val_o
);

  logic [mtwa_pkg::VAL_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shift) begin
      val_d = prev_i;
    end else if (ctl_i.rotate) begin
      val_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

[hw/rtl/mtwa_div.sv]
// Restoring divider, one quotient bit per cycle, for the rounded average.
// Depends on mtwa_pkg for operand widths; the quotient must fit in QUO_W bits.
`timescale 1ns / 1ps
`default_nettype none

module mtwa_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire  [mtwa_pkg::NUM_W-1:0]       num_i,
  input  wire  [mtwa_pkg::WSUM_W-1:0]      den_i,
  output logic                             done_o,
  output logic [mtwa_pkg::QUO_W-1:0]       quo_o
);

  localparam int STEP_W = $clog2(mtwa_pkg::QUO_W + 1);
  localparam int REM_W  = mtwa_pkg::NUM_W - mtwa_pkg::QUO_W;

  // Upper part holds the partial remainder, lower part shifts numerator
  // bits out and quotient bits in.
  logic [mtwa_pkg::NUM_W-1:0]  rq_q, rq_d;
  logic [mtwa_pkg::WSUM_W-1:0] den_q;
  logic [STEP_W-1:0]           step_q, step_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [REM_W:0]              trial;
  logic [REM_W:0]              diff;
  logic                        ge;

  always_comb begin
    trial  = rq_q[mtwa_pkg::NUM_W-1:mtwa_pkg::QUO_W-1];
    ge     = (trial >= (REM_W+1)'(den_q));
    diff   = trial - (REM_W+1)'(den_q);
    rq_d   = rq_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rq_d   = num_i;
      step_d = STEP_W'(mtwa_pkg::QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rq_d = {(ge ? diff[REM_W-1:0] : trial[REM_W-1:0]),
              rq_q[mtwa_pkg::QUO_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = rq_q[mtwa_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/median_then_weighted_average_filter.sv]
// Humidity filter: raw cells feed a sliding median; median cells rotate past one MAC.
// Non-fault items pass S_MED, the MAC pass in S_MAC, S_DST and the bit-serial divider in
// S_DIV (skipped for a zero weight sum), then S_FIN loads the output register; fault
// items go from accept straight to S_FIN. One item at a time: a reading is taken only in
// S_IDLE, and a result waits in S_FIN until the output register is free or ready is high.
// Async active-low reset loads zero windows, last output 190 and the default weights.
`timescale 1ns / 1ps
`default_nettype none
`include "median_then_weighted_average_filter_macros.svh"

module median_then_weighted_average_filter #(
  parameter int MEDIAN_TAPS  = 5,
  parameter int AVERAGE_TAPS = 4
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [mtwa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [mtwa_pkg::WGT_W-1:0]           cfg_wdata_i,
  mtwa_in_if.sink                              in_i,
  mtwa_out_if.source                           out_o
);

  localparam int RANK_W = $clog2(MEDIAN_TAPS);
  localparam int MID    = MEDIAN_TAPS / 2;
  localparam int CNT_W  = $clog2(AVERAGE_TAPS);
  localparam int PROD_W = mtwa_pkg::VAL_W + mtwa_pkg::WGT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MED  = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_DST  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [mtwa_pkg::WGT_W-1:0]  wgt_q [mtwa_pkg::WCOUNT];
  logic [mtwa_pkg::VAL_W-1:0]  last_q;
  logic                        res_fault_q;
  logic [CNT_W-1:0]            mac_cnt_q, mac_cnt_d;
  logic [mtwa_pkg::NUM_W-1:0]  acc_q, acc_d;
  logic [mtwa_pkg::WSUM_W-1:0] wsum_q, wsum_d;
  logic                        out_valid_q;
  logic [mtwa_pkg::VAL_W-1:0]  humidity_q;
  logic                        fault_q;

  logic [mtwa_pkg::VAL_W-1:0]  raw  [MEDIAN_TAPS];
  logic [mtwa_pkg::VAL_W-1:0]  mwin [AVERAGE_TAPS];
  logic [RANK_W-1:0]           rank [MEDIAN_TAPS];
  logic [mtwa_pkg::VAL_W-1:0]  med;
  logic [mtwa_pkg::WGT_W-1:0]  w_sel;
  logic [PROD_W-1:0]           prod;

  logic                        in_acc;
  logic                        out_load;
  logic                        div_start;
  logic                        div_done;
  logic [mtwa_pkg::QUO_W-1:0]  div_quo;
  logic [mtwa_pkg::NUM_W-1:0]  div_num;

  mtwa_pkg::cell_ctl_t raw_ctl, med_ctl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign raw_ctl.shift  = in_acc && !in_i.sensor_fault;
  assign raw_ctl.rotate = 1'b0;
  assign med_ctl.shift  = (state_q == S_MED);
  assign med_ctl.rotate = (state_q == S_MAC);

  // Raw window: newest reading enters cell 0.
  for (genvar i = 0; i < MEDIAN_TAPS; i++) begin : g_raw
    mtwa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (raw_ctl),
      .prev_i ((i == 0) ? in_i.reading : raw[(i + MEDIAN_TAPS - 1) % MEDIAN_TAPS]),
      .next_i (raw[i]),
      .val_o  (raw[i])
    );
  end

  // Median window: shift in the new median, then rotate toward cell 0 so
  // each median passes the multiplier once and lands back in place.
  for (genvar i = 0; i < AVERAGE_TAPS; i++) begin : g_med
    mtwa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (med_ctl),
      .prev_i ((i == 0) ? med : mwin[(i + AVERAGE_TAPS - 1) % AVERAGE_TAPS]),
      .next_i (mwin[(i + 1) % AVERAGE_TAPS]),
      .val_o  (mwin[i])
    );
  end

  // Rank each tap; ties break by position, so ranks form a permutation.
  always_comb begin
    med = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if ((raw[j] < raw[i]) || ((j < i) && (raw[j] == raw[i]))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
      if (rank[i] == RANK_W'(MID)) begin
        med = med | raw[i];
      end
    end
  end

  // Taps beyond the weight registers get weight zero.
  always_comb begin
    w_sel = '0;
    for (int j = 0; j < mtwa_pkg::WCOUNT; j++) begin
      if (int'(mac_cnt_q) == j) begin
        w_sel = wgt_q[j];
      end
    end
  end

  assign prod    = w_sel * mwin[0];
  assign div_num = acc_q + mtwa_pkg::NUM_W'(wsum_q >> 1);

  always_comb begin
    state_d   = state_q;
    mac_cnt_d = mac_cnt_q;
    acc_d     = acc_q;
    wsum_d    = wsum_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = in_i.sensor_fault ? S_FIN : S_MED;
        end
      end
      S_MED: begin
        mac_cnt_d = '0;
        acc_d     = '0;
        wsum_d    = '0;
        state_d   = S_MAC;
      end
      S_MAC: begin
        acc_d     = acc_q + mtwa_pkg::NUM_W'(prod);
        wsum_d    = wsum_q + mtwa_pkg::WSUM_W'(w_sel);
        mac_cnt_d = mac_cnt_q + CNT_W'(1);
        if (mac_cnt_q == CNT_W'(AVERAGE_TAPS - 1)) begin
          state_d = S_DST;
        end
      end
      S_DST: begin
        // Zero weight sum: hold the last output.
        if (wsum_q == '0) begin
          state_d = S_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  mtwa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (wsum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mac_cnt_q   <= '0;
      last_q      <= mtwa_pkg::LAST_RESET;
      out_valid_q <= 1'b0;
      for (int j = 0; j < mtwa_pkg::WCOUNT; j++) begin
        wgt_q[j] <= mtwa_pkg::WGT_RESET[j];
      end
    end else begin
      state_q   <= state_d;
      mac_cnt_q <= mac_cnt_d;
      if ((state_q == S_DIV) && div_done) begin
        last_q <= div_quo[mtwa_pkg::VAL_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mtwa_pkg::REG_W_NEWEST: wgt_q[0] <= cfg_wdata_i;
          mtwa_pkg::REG_W_SECOND: wgt_q[1] <= cfg_wdata_i;
          mtwa_pkg::REG_W_THIRD:  wgt_q[2] <= cfg_wdata_i;
          mtwa_pkg::REG_W_OLDEST: wgt_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    wsum_q <= wsum_d;
    if (in_acc) begin
      res_fault_q <= in_i.sensor_fault;
    end
    if (out_load) begin
      humidity_q <= last_q;
      fault_q    <= res_fault_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.humidity = humidity_q;
  assign out_o.fault    = fault_q;

  `MTWA_ASSERT_NXT(a_fault_skips, in_acc && in_i.sensor_fault, state_q == S_FIN,
                   "fault transaction did not go straight to result")
  `MTWA_ASSERT_IMP(a_div_in_state, div_done, state_q == S_DIV,
                   "divider finished outside the divide state")
  `MTWA_ASSERT_NXT(a_mac_start, state_q == S_MED, mac_cnt_q == '0 && acc_q == '0,
                   "accumulate pass did not start clear")
  `MTWA_ASSERT_NXT(a_result_loaded, out_load, out_valid_q && humidity_q == $past(last_q),
                   "result register not loaded with the held output")

endmodule

`default_nettype wire
